// ===== rtl/lzfd_pkg.sv =====
`timescale 1ns / 1ps

package lzfd_pkg;

    // Byte lane width of the compressed and decompressed streams.
    localparam int BYTE_W = 8;

    // Default history window depth in bytes.
    localparam int WINDOW_DEPTH_DEF = 4096;

    // Width of the declared output size and of the produced byte count.
    localparam int SIZE_W = 24;

    // A reference copies at least this many bytes.
    localparam int MIN_MATCH = 3;

    // Width of a reference distance (12 bits plus one, up to 4096).
    localparam int DISP_W = 13;

    // Width of a reference length (3 to 18).
    localparam int LEN_W = 5;

    // Number of flag bits in one flag byte.
    localparam int FLAG_BITS = 8;

endpackage

// ===== rtl/lzfd_window.sv =====
`timescale 1ns / 1ps

module lzfd_window #(
    parameter int WINDOW_DEPTH = lzfd_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                wr_en,
    input  logic [$clog2(WINDOW_DEPTH)-1:0]     wr_addr,
    input  logic [lzfd_pkg::BYTE_W-1:0]         wr_data,
    input  logic [$clog2(WINDOW_DEPTH)-1:0]     rd_addr,
    output logic [lzfd_pkg::BYTE_W-1:0]         rd_data
);

    logic [lzfd_pkg::BYTE_W-1:0] mem [WINDOW_DEPTH];
    logic [lzfd_pkg::BYTE_W-1:0] rd_q_reg;
    logic [lzfd_pkg::BYTE_W-1:0] fwd_data_reg;
    logic                        fwd_reg;

    // The array reads the old contents on a same-address write, so the
    // written byte is bypassed around it for the following cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_q_reg     <= mem[rd_addr];
        fwd_reg      <= wr_en && (wr_addr == rd_addr);
        fwd_data_reg <= wr_data;
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rd_q_reg;

endmodule

// ===== rtl/lz77_flag_block_decompressor.sv =====
`timescale 1ns / 1ps

// LZ77 type-10 decompressor. It takes the compressed stream one byte per
// input beat: a type byte (ignored), three size bytes (little endian), then
// flag bytes read most significant bit first, each bit choosing either one
// literal byte or a two-byte back reference (length = high nibble + 3,
// distance = low 12 bits + 1). Every output beat carries one decompressed
// byte; last_of_run marks the final byte caused by an input beat and
// stream_done the byte that reaches the declared size, after which the
// next input byte starts a new stream. Copies whose source lies before the
// first byte of the current stream give zero with bad_reference set.
// Timing: header and flag bytes are taken whenever presented; literal and
// first reference bytes wait for a free output register. After the second
// reference byte the copy first issues its window read, then emits one
// copied byte per cycle (3 to 18) while the output register is free, since
// the history window is a single synchronous memory with one read and one
// write port and a registered read, and overlapping copies are served by
// a bypass of the same-cycle write. Input is not accepted while a copy runs.
// The window needs no clearing after reset: a valid stream never reads an
// entry that the current stream has not written.
module lz77_flag_block_decompressor #(
    parameter int WINDOW_DEPTH = lzfd_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lzfd_pkg::BYTE_W-1:0]   s_in_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lzfd_pkg::BYTE_W-1:0]   m_out_byte,
    output logic                          m_last_of_run,
    output logic                          m_stream_done,
    output logic                          m_bad_reference
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int XW = AW + 1;

    typedef enum logic [2:0] {
        ST_TYPE,
        ST_SIZE0,
        ST_SIZE1,
        ST_SIZE2,
        ST_FLAG,
        ST_TOKEN,
        ST_REF2,
        ST_COPY
    } state_t;

    state_t                            phase_reg, phase_next;
    logic [AW-1:0]                     wp_reg, wp_next;
    logic [lzfd_pkg::SIZE_W-1:0]       declared_reg, declared_next;
    logic [lzfd_pkg::SIZE_W-1:0]       produced_reg, produced_next;
    logic [lzfd_pkg::BYTE_W-1:0]       flag_bits_reg, flag_bits_next;
    logic [3:0]                        flag_pos_reg, flag_pos_next;
    logic [lzfd_pkg::BYTE_W-1:0]       ref_hi_reg, ref_hi_next;
    logic [lzfd_pkg::DISP_W-1:0]       disp_reg, disp_next;
    logic [lzfd_pkg::LEN_W-1:0]        remain_reg, remain_next;
    logic                              pend_reg, pend_next;

    logic                              m_valid_reg, m_valid_next;
    logic [lzfd_pkg::BYTE_W-1:0]       out_byte_reg, out_byte_next;
    logic                              last_reg, last_next;
    logic                              done_reg, done_next;
    logic                              bad_reg, bad_next;

    logic                              out_free;
    logic                              accept;
    logic                              copy_emit;
    logic                              done_now;
    logic                              bad_now;
    logic [AW-1:0]                     wp_inc;
    logic [AW-1:0]                     wp_rd;
    logic [XW-1:0]                     wp_rd_ext;
    logic [XW-1:0]                     disp_ext;
    logic [XW-1:0]                     src_ext;
    logic [lzfd_pkg::SIZE_W-1:0]       prod_inc;
    logic [3:0]                        pos_inc;
    state_t                            after_phase;

    logic                              wr_en;
    logic [lzfd_pkg::BYTE_W-1:0]       wr_data;
    logic [AW-1:0]                     rd_addr;
    logic [lzfd_pkg::BYTE_W-1:0]       rd_data;

    lzfd_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_window (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The output register can take a new byte when it is empty or being
    // drained in this cycle.
    assign out_free = !m_valid_reg || m_ready;

    // Header and flag bytes never wait on the output side; a token byte may
    // produce a literal, so it waits for a free output register.
    assign s_ready = (phase_reg != ST_COPY) && ((phase_reg != ST_TOKEN) || out_free);
    assign accept  = s_valid && s_ready;

    // A copy byte goes out once its window read has landed.
    assign copy_emit = (phase_reg == ST_COPY) && pend_reg && out_free;

    assign wp_inc   = (wp_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign prod_inc = produced_reg + 1'b1;
    assign done_now = prod_inc >= declared_reg;
    assign bad_now  = produced_reg < lzfd_pkg::SIZE_W'(disp_reg);

    // The next copy source is taken relative to the write pointer as it
    // stands after this cycle, wrapping around the window.
    assign wp_rd     = copy_emit ? wp_inc : wp_reg;
    assign wp_rd_ext = {1'b0, wp_rd};
    assign disp_ext  = XW'(disp_reg);
    assign src_ext   = (wp_rd_ext >= disp_ext) ? (wp_rd_ext - disp_ext)
                                               : (wp_rd_ext + XW'(WINDOW_DEPTH) - disp_ext);
    assign rd_addr   = src_ext[AW-1:0];

    // Flag bookkeeping once a token has finished.
    assign pos_inc = flag_pos_reg + 4'd1;
    always_comb begin
        priority if (done_now) begin
            after_phase = ST_TYPE;
        end else if (pos_inc >= 4'(lzfd_pkg::FLAG_BITS)) begin
            after_phase = ST_FLAG;
        end else begin
            after_phase = ST_TOKEN;
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        wp_next        = wp_reg;
        declared_next  = declared_reg;
        produced_next  = produced_reg;
        flag_bits_next = flag_bits_reg;
        flag_pos_next  = flag_pos_reg;
        ref_hi_next    = ref_hi_reg;
        disp_next      = disp_reg;
        remain_next    = remain_reg;
        pend_next      = pend_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        done_next      = done_reg;
        bad_next       = bad_reg;
        m_valid_next   = m_ready ? 1'b0 : m_valid_reg;
        wr_en          = 1'b0;
        wr_data        = s_in_byte;

        unique case (phase_reg)
            ST_TYPE: begin
                if (accept) begin
                    phase_next = ST_SIZE0;
                end
            end
            ST_SIZE0: begin
                if (accept) begin
                    declared_next = lzfd_pkg::SIZE_W'(s_in_byte);
                    phase_next    = ST_SIZE1;
                end
            end
            ST_SIZE1: begin
                if (accept) begin
                    declared_next = {8'd0, s_in_byte, declared_reg[7:0]};
                    phase_next    = ST_SIZE2;
                end
            end
            ST_SIZE2: begin
                if (accept) begin
                    declared_next = {s_in_byte, declared_reg[15:0]};
                    produced_next = '0;
                    flag_pos_next = 4'(lzfd_pkg::FLAG_BITS);
                    // An empty stream ends here without any output.
                    phase_next    = ({s_in_byte, declared_reg[15:0]} == '0) ? ST_TYPE
                                                                            : ST_FLAG;
                end
            end
            ST_FLAG: begin
                if (accept) begin
                    flag_bits_next = s_in_byte;
                    flag_pos_next  = '0;
                    phase_next     = ST_TOKEN;
                end
            end
            ST_TOKEN: begin
                if (accept) begin
                    if (!flag_bits_reg[~flag_pos_reg[2:0]]) begin
                        // Literal: store it and send it out directly.
                        wr_en         = 1'b1;
                        wp_next       = wp_inc;
                        produced_next = prod_inc;
                        m_valid_next  = 1'b1;
                        out_byte_next = s_in_byte;
                        last_next     = 1'b1;
                        done_next     = done_now;
                        bad_next      = 1'b0;
                        flag_pos_next = pos_inc;
                        phase_next    = after_phase;
                    end else begin
                        ref_hi_next = s_in_byte;
                        phase_next  = ST_REF2;
                    end
                end
            end
            ST_REF2: begin
                if (accept) begin
                    disp_next   = lzfd_pkg::DISP_W'({ref_hi_reg[3:0], s_in_byte}) + 1'b1;
                    remain_next = lzfd_pkg::LEN_W'(ref_hi_reg[7:4])
                                + lzfd_pkg::LEN_W'(lzfd_pkg::MIN_MATCH);
                    pend_next   = 1'b0;
                    phase_next  = ST_COPY;
                end
            end
            ST_COPY: begin
                // A read is issued every cycle, so the window output is
                // always current once pend_reg is set.
                pend_next = 1'b1;
                if (copy_emit) begin
                    wr_data       = bad_now ? '0 : rd_data;
                    wr_en         = 1'b1;
                    wp_next       = wp_inc;
                    produced_next = prod_inc;
                    remain_next   = remain_reg - 1'b1;
                    m_valid_next  = 1'b1;
                    out_byte_next = bad_now ? '0 : rd_data;
                    last_next     = done_now || (remain_reg == lzfd_pkg::LEN_W'(1));
                    done_next     = done_now;
                    bad_next      = bad_now;
                    if (done_now || (remain_reg == lzfd_pkg::LEN_W'(1))) begin
                        flag_pos_next = pos_inc;
                        phase_next    = after_phase;
                    end
                end
            end
            default: begin
                phase_next = ST_SIZE0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= ST_TYPE;
            wp_reg        <= '0;
            declared_reg  <= '0;
            produced_reg  <= '0;
            flag_bits_reg <= '0;
            flag_pos_reg  <= 4'(lzfd_pkg::FLAG_BITS);
            ref_hi_reg    <= '0;
            pend_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            wp_reg        <= wp_next;
            declared_reg  <= declared_next;
            produced_reg  <= produced_next;
            flag_bits_reg <= flag_bits_next;
            flag_pos_reg  <= flag_pos_next;
            ref_hi_reg    <= ref_hi_next;
            pend_reg      <= pend_next;
            m_valid_reg   <= m_valid_next;
        end
        disp_reg     <= disp_next;
        remain_reg   <= remain_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
        done_reg     <= done_next;
        bad_reg      <= bad_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_out_byte      = out_byte_reg;
    assign m_last_of_run   = last_reg;
    assign m_stream_done   = done_reg;
    assign m_bad_reference = bad_reg;

    // A beat that reaches the declared size also ends its input beat's run.
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stream_done |-> m_last_of_run)
        else $error("stream_done beat without last_of_run");

    // A reference that reaches before the stream start yields a zero byte.
    a_bad_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_reference |-> (m_out_byte == '0))
        else $error("bad_reference beat carries a nonzero byte");

    // While tokens are being decoded the stream has not yet reached its size.
    a_count_below_size: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == ST_TOKEN) || (phase_reg == ST_REF2) || (phase_reg == ST_COPY)
        |-> (produced_reg < declared_reg))
        else $error("produced count reached the declared size while decoding");

    // The copy that completes the stream hands control back to the header.
    a_done_ends_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        copy_emit && done_now |=> (phase_reg == ST_TYPE))
        else $error("copy continued past the declared size");

endmodule
